[design/scrambled_hdlc_frame_receiver_assert.svh]
// assertion macros for the scrambled hdlc frame receiver modules
// depends on nothing; included by shfr_fifo, which checks its own logic
`ifndef SCRAMBLED_HDLC_FRAME_RECEIVER_ASSERT_SVH
`define SCRAMBLED_HDLC_FRAME_RECEIVER_ASSERT_SVH

// expression holds at every clock edge out of reset
`define SHFR_ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("shfr check failed");

// consequent holds in the same cycle as the antecedent
`define SHFR_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("shfr check failed");

// consequent holds in the cycle after the antecedent
`define SHFR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("shfr check failed");

`endif

[design/shfr_pkg.sv]
// types and constants of the scrambled hdlc frame receiver
// depends on nothing; used by every module of the block
package shfr_pkg;

    // register reset values
    localparam logic [31:0] TAPS_RESET    = 32'h0003_1801;
    localparam logic [31:0] SEED_RESET    = 32'hF185_D3AC;
    localparam logic        INVERT_RESET  = 1'b1;
    localparam logic [1:0]  SKIP_RESET    = 2'd1;
    localparam logic [5:0]  MIN_LEN_RESET = 6'd41;
    localparam logic [15:0] RESIDUE_RESET = 16'hF0B8;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;

    // result queue sizing
    localparam int ITEM_MAX   = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_TAPS    = 3'd0,
        REG_SEED    = 3'd1,
        REG_INVERT  = 3'd2,
        REG_SKIP    = 3'd3,
        REG_MIN_LEN = 3'd4,
        REG_RESIDUE = 3'd5
    } reg_idx_e;

    typedef struct packed {
        logic [31:0] taps;
        logic [31:0] seed;
        logic        invert;
        logic [1:0]  skip;
        logic [5:0]  min_len;
        logic [15:0] residue;
    } cfg_t;

    typedef struct packed {
        logic [7:0] frame_length;
        logic       crc_ok;
        logic       frame_end;
        logic       byte_valid;
        logic [7:0] out_byte;
    } item_t;

    // results of one input byte handed to the queue
    typedef struct packed {
        logic [1:0]                n;
        item_t [ITEM_MAX-1:0]      items;
    } push_t;

endpackage

[design/shfr_regs.sv]
// apb configuration registers of the frame receiver
// depends on shfr_pkg
module shfr_regs import shfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    reg_idx_e idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_e'(paddr[4:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.taps    <= TAPS_RESET;
            cfg_reg.seed    <= SEED_RESET;
            cfg_reg.invert  <= INVERT_RESET;
            cfg_reg.skip    <= SKIP_RESET;
            cfg_reg.min_len <= MIN_LEN_RESET;
            cfg_reg.residue <= RESIDUE_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_TAPS:    cfg_reg.taps    <= pwdata;
                REG_SEED:    cfg_reg.seed    <= pwdata;
                REG_INVERT:  cfg_reg.invert  <= pwdata[0];
                REG_SKIP:    cfg_reg.skip    <= pwdata[1:0];
                REG_MIN_LEN: cfg_reg.min_len <= pwdata[5:0];
                REG_RESIDUE: cfg_reg.residue <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_TAPS:    prdata = cfg_reg.taps;
            REG_SEED:    prdata = cfg_reg.seed;
            REG_INVERT:  prdata = {31'd0, cfg_reg.invert};
            REG_SKIP:    prdata = {30'd0, cfg_reg.skip};
            REG_MIN_LEN: prdata = {26'd0, cfg_reg.min_len};
            REG_RESIDUE: prdata = {16'd0, cfg_reg.residue};
            default:     prdata = '0;
        endcase
    end

endmodule

[design/shfr_core.sv]
// input register, descrambler, destuffer, crc and realigner of the frame receiver
// depends on shfr_pkg
module shfr_core import shfr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       fifo_room,
    output push_t      push
);

    // input register
    logic       in_valid_reg;
    logic [7:0] raw_reg;
    logic       last_reg;

    // frame state
    logic [31:0] shift_reg, shift_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [2:0]  ones_run_reg, ones_run_next;
    logic [7:0]  partial_byte_reg, partial_byte_next;
    logic [2:0]  partial_bits_reg, partial_bits_next;
    logic [3:0]  held_nibble_reg, held_nibble_next;
    logic        nibble_held_reg, nibble_held_next;
    logic [15:0] crc_reg, crc_next;
    logic [5:0]  dcount_reg, dcount_next;
    logic [1:0]  lead_count_reg, lead_count_next;

    logic  fire;
    item_t [ITEM_MAX-1:0] items;
    logic [1:0] n_items;

    assign fire     = in_valid_reg & fifo_room;
    assign s_tready = ~in_valid_reg | fire;

    // one byte through the reflected ccitt crc
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = b ^ crc[7:0];
        x = x ^ {x[3:0], 4'd0};
        return {x, crc[15:8]} ^ {12'd0, x[7:4]} ^ {5'd0, x, 3'd0};
    endfunction

    // input register loads whenever the previous request moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            raw_reg  <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    // all work for one byte
    always_comb begin : step_logic
        logic [39:0] win;
        logic [7:0]  dsc;
        logic [7:0]  pb;
        logic [3:0]  pbits;
        logic [2:0]  orun;
        logic [3:0]  hn;
        logic        hf;
        logic [1:0]  n;
        logic        full;
        logic [7:0]  full_byte;
        logic [7:0]  left;
        logic [15:0] crc;
        logic [5:0]  dcnt;
        logic [7:0]  bcnt;

        win       = {shift_reg, raw_reg};
        dsc       = '0;
        pb        = partial_byte_reg;
        pbits     = {1'b0, partial_bits_reg};
        orun      = ones_run_reg;
        hn        = held_nibble_reg;
        hf        = nibble_held_reg;
        n         = '0;
        full      = 1'b0;
        full_byte = '0;
        left      = '0;
        crc       = crc_reg;
        dcnt      = dcount_reg;
        bcnt      = byte_count_reg;
        items     = '0;

        // descrambler: each bit sees its own 32-bit window of the history
        for (int j = 0; j < 8; j++) begin
            dsc[7-j] = raw_reg[7-j] ^ (^(win[39-j -: 32] & cfg.taps));
        end
        shift_next = win[31:0];
        if (cfg.invert) begin
            dsc = ~dsc;
        end

        lead_count_next = lead_count_reg;
        if (lead_count_reg < cfg.skip) begin
            lead_count_next = lead_count_reg + 2'd1;
        end else begin
            if (bcnt != 8'hFF) begin
                bcnt = bcnt + 8'd1;
            end
            // bit destuffing, lsb-first repacking
            for (int i = 7; i >= 0; i--) begin
                if (orun >= 3'd5 && !dsc[i]) begin
                    orun = 3'd0;
                end else begin
                    if (dsc[i]) begin
                        orun = (orun != 3'd7) ? orun + 3'd1 : 3'd7;
                    end else begin
                        orun = 3'd0;
                    end
                    pb    = {dsc[i], pb[7:1]};
                    pbits = pbits + 4'd1;
                    if (pbits == 4'd8) begin
                        full      = 1'b1;
                        full_byte = pb;
                        pbits     = 4'd0;
                        pb        = '0;
                    end
                end
            end
            // crc, count and realign of a completed byte
            if (full) begin
                if (dcnt < cfg.min_len) begin
                    crc = crc_step(crc, full_byte);
                end
                if (dcnt != 6'd63) begin
                    dcnt = dcnt + 6'd1;
                end
                if (hf) begin
                    items[n].out_byte   = {hn, full_byte[7:4]};
                    items[n].byte_valid = 1'b1;
                    n = n + 2'd1;
                end
                hn = full_byte[3:0];
                hf = 1'b1;
            end
        end

        ones_run_next     = orun;
        partial_byte_next = pb;
        partial_bits_next = pbits[2:0];
        held_nibble_next  = hn;
        nibble_held_next  = hf;
        crc_next          = crc;
        dcount_next       = dcnt;
        byte_count_next   = bcnt;

        // frame close: leftover bits, closing item, restart
        if (last_reg) begin
            if (pbits != 4'd0) begin
                left = pb >> (4'd8 - pbits);
                if (hf) begin
                    items[n].out_byte   = {hn, left[7:4]};
                    items[n].byte_valid = 1'b1;
                    n = n + 2'd1;
                end
                hn = left[3:0];
                hf = 1'b1;
            end
            items[n].out_byte     = hf ? {hn, 4'd0} : 8'd0;
            items[n].byte_valid   = hf;
            items[n].frame_end    = 1'b1;
            items[n].crc_ok       = (dcnt >= cfg.min_len) && (crc == cfg.residue);
            items[n].frame_length = bcnt;
            n = n + 2'd1;

            shift_next        = cfg.seed;
            byte_count_next   = '0;
            ones_run_next     = '0;
            partial_byte_next = '0;
            partial_bits_next = '0;
            held_nibble_next  = '0;
            nibble_held_next  = 1'b0;
            crc_next          = CRC_INIT;
            dcount_next       = '0;
            lead_count_next   = '0;
        end
        n_items = n;
    end

    assign push.n     = fire ? n_items : 2'd0;
    assign push.items = items;

    // frame state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg        <= SEED_RESET;
            byte_count_reg   <= '0;
            ones_run_reg     <= '0;
            partial_byte_reg <= '0;
            partial_bits_reg <= '0;
            held_nibble_reg  <= '0;
            nibble_held_reg  <= 1'b0;
            crc_reg          <= CRC_INIT;
            dcount_reg       <= '0;
            lead_count_reg   <= '0;
        end else if (fire) begin
            shift_reg        <= shift_next;
            byte_count_reg   <= byte_count_next;
            ones_run_reg     <= ones_run_next;
            partial_byte_reg <= partial_byte_next;
            partial_bits_reg <= partial_bits_next;
            held_nibble_reg  <= held_nibble_next;
            nibble_held_reg  <= nibble_held_next;
            crc_reg          <= crc_next;
            dcount_reg       <= dcount_next;
            lead_count_reg   <= lead_count_next;
        end
    end

endmodule

[design/shfr_fifo.sv]
// result queue of the frame receiver: takes up to three results a cycle, gives one
// depends on shfr_pkg and scrambled_hdlc_frame_receiver_assert.svh
`include "scrambled_hdlc_frame_receiver_assert.svh"

module shfr_fifo import shfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  push_t       push,
    output logic        fifo_room,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    item_t            mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    item_t            head;

    assign pop       = m_tvalid & m_tready;
    assign count_next = count_reg + CNT_W'(push.n) - CNT_W'(pop);
    // room for a full burst of results from one byte
    assign fifo_room = (count_reg <= CNT_W'(FIFO_DEPTH - ITEM_MAX));

    // entry writes
    always_ff @(posedge aclk) begin
        for (int k = 0; k < ITEM_MAX; k++) begin
            if (k < int'(push.n)) begin
                mem[wr_ptr_reg + PTR_W'(k)] <= push.items[k];
            end
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.n);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    // head of queue onto the result channel
    assign head     = mem[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {7'd0, head.frame_length, head.crc_ok, head.out_byte};
    assign m_tuser  = head.byte_valid;
    assign m_tlast  = head.frame_end;

    `SHFR_ASSERT_ALWAYS(a_no_overflow, aclk, aresetn, count_reg <= CNT_W'(FIFO_DEPTH))
    `SHFR_ASSERT_IMPLIES(a_push_has_room, aclk, aresetn, push.n != 2'd0, fifo_room)
    `SHFR_ASSERT_NEXT(a_pop_drains, aclk, aresetn, pop && push.n == 2'd0, count_reg == $past(count_reg) - CNT_W'(1))

endmodule

[design/scrambled_hdlc_frame_receiver.sv]
// top level of the scrambled hdlc frame receiver
// depends on shfr_pkg, shfr_regs, shfr_core, shfr_fifo
//
// channel   dir  ports                               content
// s_        in   s_tvalid s_tready s_tdata s_tlast   raw_byte; tlast = last_byte
// m_        out  m_tvalid m_tready m_tdata m_tuser   out_byte, crc_ok, frame_length
//                m_tlast                             tuser = byte_valid, tlast = frame_end
// apb       in   psel penable pwrite paddr pwdata    six registers at 4*index
//
// one input byte per cycle while the result queue has room; a byte is worked
// between the input register and the result queue once it sits in the input register.
// a closing byte yields up to three results, the queue drains one per cycle while
// m_tready is high, so the input stalls after a frame end until the queue is back to one result.
// the input accepts while its register is empty or the queue holds at most one result.
// synchronous active-low reset; no clearing pass.
module scrambled_hdlc_frame_receiver import shfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] raw_byte
    input  logic        s_tlast,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [8] crc_ok, [16:9] frame_length
    output logic        m_tuser,   // [0] byte_valid
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t  cfg;
    push_t push;
    logic  fifo_room;

    shfr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    shfr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fifo_room (fifo_room),
        .push      (push)
    );

    shfr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .fifo_room (fifo_room),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
